// ----- design/sfd_pkg.sv -----
// Shared types, constants and helpers for the shutdown frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int FRAME_BYTES_DEFAULT = 48;
    localparam int INDEX_W = 9;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd511;

    localparam logic [31:0] MAGIC_WORD   = 32'h4453_4958;
    localparam logic [15:0] TYPE_REQUEST = 16'd1;
    localparam logic [15:0] TYPE_ACK     = 16'd2;
    localparam logic [15:0] VERSION_WORD = 16'd1;

    localparam logic [INDEX_W-1:0] HEADER_END   = 9'd8;
    localparam logic [INDEX_W-1:0] CODE_POS     = 9'd40;
    localparam logic [INDEX_W-1:0] RESERVED_POS = 9'd41;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_MODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_STOP_CODE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTED_CODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALREADY_STOPPING = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REJECTED_CODE    = 3'd4;

    localparam logic [7:0] ALREADY_STOPPING_RESET = 8'd1;
    localparam logic [7:0] REJECTED_RESET         = 8'd2;

    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_BAD_LENGTH   = 3'd1;
    localparam logic [2:0] STATUS_BAD_HEADER   = 3'd2;
    localparam logic [2:0] STATUS_RESERVED     = 3'd3;
    localparam logic [2:0] STATUS_INVALID      = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] generation;
        logic [63:0] epoch;
        logic [63:0] identity;
        logic [63:0] time_ns;
        logic [7:0]  code;
    } result_t;

    typedef struct packed {
        logic       frame_mode;
        logic [7:0] force_stop_code;
        logic [7:0] accepted_code;
        logic [7:0] already_stopping_code;
        logic [7:0] rejected_code;
    } cfg_t;

    // one classified frame byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       header_bad;
        logic       reserved_bad;
        logic       is_field;
        logic [1:0] field_sel;
        logic [2:0] lane;
        logic       is_code;
        logic       last;
        logic       length_ok;
    } byte_class_t;

    function automatic logic [7:0] header_byte(input logic [2:0] pos, input logic mode);
        logic [15:0] type_word;
        type_word = mode ? TYPE_ACK : TYPE_REQUEST;
        unique case (pos)
            3'd0, 3'd1, 3'd2, 3'd3: header_byte = MAGIC_WORD[{pos[1:0], 3'b000} +: 8];
            3'd4, 3'd5:             header_byte = type_word[{pos[0], 3'b000} +: 8];
            default:                header_byte = VERSION_WORD[{pos[0], 3'b000} +: 8];
        endcase
    endfunction

endpackage

// ----- design/sfd_fifo.sv -----
// Small first-in first-out queue of packed items.
`timescale 1ns / 1ps

module sfd_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    T                 mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/sfd_front.sv -----
// Front end: tracks the byte position and classifies each incoming frame byte.
`timescale 1ns / 1ps

module sfd_front #(
    parameter int FRAME_BYTES = sfd_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  sfd_pkg::item_t      item,
    input  logic                frame_mode,
    output sfd_pkg::byte_class_t cls
);
    import sfd_pkg::*;

    localparam logic [INDEX_W-1:0] FRAME_LEN = INDEX_W'(FRAME_BYTES);

    logic [INDEX_W-1:0] index_reg, index_next;
    logic [INDEX_W-1:0] count_inc;
    logic [1:0]         field_idx;
    logic               in_frame;

    assign count_inc = (index_reg < INDEX_MAX) ? index_reg + 1'b1 : index_reg;
    assign in_frame  = (index_reg < FRAME_LEN);
    assign field_idx = index_reg[4:3] - 2'd1;

    always_comb
    begin
        cls              = '0;
        cls.data_byte    = item.data_byte;
        cls.last         = item.last;
        cls.length_ok    = (count_inc == FRAME_LEN);
        cls.lane         = index_reg[2:0];
        cls.field_sel    = field_idx;
        if (in_frame)
        begin
            if (index_reg < HEADER_END)
            begin
                cls.header_bad = (item.data_byte != header_byte(index_reg[2:0], frame_mode));
            end
            else if (index_reg < CODE_POS)
            begin
                cls.is_field = 1'b1;
            end
            else if (index_reg == CODE_POS)
            begin
                cls.is_code = 1'b1;
            end
            else if (index_reg >= RESERVED_POS)
            begin
                cls.reserved_bad = (item.data_byte != 8'd0);
            end
        end
    end

    always_comb
    begin
        index_next = index_reg;
        if (accept)
        begin
            index_next = item.last ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
        end
        else
        begin
            index_reg <= index_next;
        end
    end

endmodule

// ----- design/sfd_back.sv -----
// Back end: assembles the frame fields and judges the frame at its last byte.
`timescale 1ns / 1ps

module sfd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfd_pkg::cfg_t        cfg,
    input  logic                 cls_valid,
    input  sfd_pkg::byte_class_t cls,
    output logic                 cls_take,
    input  logic                 res_full,
    output logic                 res_push,
    output sfd_pkg::result_t     res
);
    import sfd_pkg::*;

    logic [63:0] acc_reg [4];
    logic [63:0] acc_next [4];
    logic [7:0]  code_reg, code_next;
    logic        header_err_reg, header_err_next;
    logic        reserved_err_reg, reserved_err_next;
    logic [63:0] shifted;
    logic        any_zero;
    logic        code_ok;
    logic        show;

    assign cls_take = cls_valid && (!cls.last || !res_full);
    assign res_push = cls_take && cls.last;
    assign shifted  = {56'd0, cls.data_byte} << {cls.lane, 3'b000};

    always_comb
    begin
        for (int f = 0; f < 4; f++)
        begin
            acc_next[f] = acc_reg[f];
            if (cls.is_field && (cls.field_sel == 2'(f)))
            begin
                acc_next[f] = acc_reg[f] | shifted;
            end
        end
        code_next         = cls.is_code ? cls.data_byte : code_reg;
        header_err_next   = header_err_reg | cls.header_bad;
        reserved_err_next = reserved_err_reg | cls.reserved_bad;
    end

    always_comb
    begin
        any_zero = (acc_next[0] == '0) || (acc_next[1] == '0) ||
                   (acc_next[2] == '0) || (acc_next[3] == '0);
        if (!cfg.frame_mode)
        begin
            code_ok = (code_next == cfg.force_stop_code);
        end
        else
        begin
            code_ok = (code_next == cfg.accepted_code) ||
                      (code_next == cfg.already_stopping_code) ||
                      (code_next == cfg.rejected_code);
        end

        if (!cls.length_ok)
        begin
            res.status = STATUS_BAD_LENGTH;
        end
        else if (header_err_next)
        begin
            res.status = STATUS_BAD_HEADER;
        end
        else if (reserved_err_next)
        begin
            res.status = STATUS_RESERVED;
        end
        else if (any_zero || !code_ok)
        begin
            res.status = STATUS_INVALID;
        end
        else
        begin
            res.status = STATUS_OK;
        end

        show           = (res.status == STATUS_OK) || (res.status == STATUS_INVALID);
        res.generation = show ? acc_next[0] : '0;
        res.epoch      = show ? acc_next[1] : '0;
        res.identity   = show ? acc_next[2] : '0;
        res.time_ns    = show ? acc_next[3] : '0;
        res.code       = show ? code_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < 4; f++)
            begin
                acc_reg[f] <= '0;
            end
            code_reg         <= '0;
            header_err_reg   <= 1'b0;
            reserved_err_reg <= 1'b0;
        end
        else if (cls_take)
        begin
            if (cls.last)
            begin
                for (int f = 0; f < 4; f++)
                begin
                    acc_reg[f] <= '0;
                end
                code_reg         <= '0;
                header_err_reg   <= 1'b0;
                reserved_err_reg <= 1'b0;
            end
            else
            begin
                for (int f = 0; f < 4; f++)
                begin
                    acc_reg[f] <= acc_next[f];
                end
                code_reg         <= code_next;
                header_err_reg   <= header_err_next;
                reserved_err_reg <= reserved_err_next;
            end
        end
    end

endmodule

// ----- design/shutdown_frame_decoder.sv -----
// Top level of the shutdown frame decoder.
//
// Usage:
//   Frame bytes enter on item (data_byte, last) through push/full, one
//   request per cycle while full is low. The final byte carries last.
//   One result per frame leaves on result through empty/pop: its status
//   and, if OK or invalid, the assembled 64-bit fields and code byte.
//   Registers are written through cfg_write/cfg_index/cfg_data while idle.
// Timing:
//   Each byte is classified as it is accepted and queued; the back end
//   folds one byte per cycle, while the result queue has room, into the
//   field accumulators. The last byte is registered in the middle queue;
//   the back end then writes its result into the output queue for pop.
//   Sustained rate is one byte per cycle while results are popped, set
//   by the single-byte accumulator update in the back end.
// Reset:
//   rst_n clears the byte position, accumulators, queues and registers
//   (codes reset to 0, 0, 1, 2; mode to request frames).
// Stall:
//   While pop is held low, up to two results wait in the output queue and
//   two bytes in the middle queue; full then rises and holds the input.
`timescale 1ns / 1ps

module shutdown_frame_decoder #(
    parameter int FRAME_BYTES = sfd_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sfd_pkg::item_t                item,
    output logic                          empty,
    input  logic                          pop,
    output sfd_pkg::result_t              result,
    input  logic                          cfg_write,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import sfd_pkg::*;

    cfg_t        cfg_reg;
    byte_class_t front_cls;
    byte_class_t mid_cls;
    logic        accept;
    logic        mid_empty;
    logic        mid_take;
    logic        res_full;
    logic        res_push;
    result_t     back_res;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_mode            <= 1'b0;
            cfg_reg.force_stop_code       <= '0;
            cfg_reg.accepted_code         <= '0;
            cfg_reg.already_stopping_code <= ALREADY_STOPPING_RESET;
            cfg_reg.rejected_code         <= REJECTED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_MODE:       cfg_reg.frame_mode            <= cfg_data[0];
                REG_FORCE_STOP_CODE:  cfg_reg.force_stop_code       <= cfg_data;
                REG_ACCEPTED_CODE:    cfg_reg.accepted_code         <= cfg_data;
                REG_ALREADY_STOPPING: cfg_reg.already_stopping_code <= cfg_data;
                REG_REJECTED_CODE:    cfg_reg.rejected_code         <= cfg_data;
                default:              ;
            endcase
        end
    end

    sfd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .frame_mode (cfg_reg.frame_mode),
        .cls        (front_cls)
    );

    sfd_fifo #(
        .T     (byte_class_t),
        .DEPTH (2)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cls),
        .full    (full),
        .rd_en   (mid_take),
        .rd_data (mid_cls),
        .empty   (mid_empty)
    );

    sfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cls_valid (!mid_empty),
        .cls       (mid_cls),
        .cls_take  (mid_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    sfd_fifo #(
        .T     (result_t),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the shutdown frame decoder: frame stimulus, predictor, checker.
`timescale 1ns / 1ps

module testbench;
    import sfd_pkg::*;

    localparam int FRAME_LEN       = FRAME_BYTES_DEFAULT;
    localparam int MAX_GAP         = 18;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_CYCLES     = 8;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_BYTES     = 16;
    localparam int BURST_FRAMES    = 40;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        int      length;
        int      fill;
        bit      noise;
        bit      hdr_fault;
        bit      zero_field;
        bit      code_fault;
        bit      rsv_fault;
        bit      typed;
        result_t typed_result;
    } frame_row_t;

    localparam result_t LENGTH_FAULT   = '{STATUS_BAD_LENGTH, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0};
    localparam result_t HEADER_FAULT   = '{STATUS_BAD_HEADER, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0};
    localparam result_t RESERVED_FAULT = '{STATUS_RESERVED, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0};
    localparam result_t ZERO_FIELDS    = '{STATUS_INVALID, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0};
    localparam result_t ALL_ONES_OK    = '{STATUS_OK, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                                           {64{1'b1}}, 8'h00};

    // length, fill, noise, hdr, zero field, code, reserved, typed, typed result
    frame_row_t directed_rows[16] = '{
        '{48,  255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ALL_ONES_OK},
        '{48,    1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, result_t'(0)},
        '{48,   -1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, result_t'(0)},
        '{48,   -1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, result_t'(0)},
        '{48,   -1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, result_t'(0)},
        '{48,    0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ZERO_FIELDS},
        '{1,    -1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, LENGTH_FAULT},
        '{47,   -1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, LENGTH_FAULT},
        '{49,   -1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, LENGTH_FAULT},
        '{530,  -1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, LENGTH_FAULT},
        '{48,   -1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, HEADER_FAULT},
        '{48,   -1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, RESERVED_FAULT},
        '{5,    -1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, LENGTH_FAULT},
        '{48,   -1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, HEADER_FAULT},
        '{48,   -1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, RESERVED_FAULT},
        '{48,   -1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, result_t'(0)}
    };

    localparam cfg_t PHASE_SETTINGS[5] = '{
        '{1'b1, 8'h00, 8'h00, 8'h01, 8'h02},
        '{1'b0, 8'hFF, 8'h00, 8'h00, 8'h00},
        '{1'b1, 8'h5A, 8'hFF, 8'h00, 8'h80},
        '{1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF},
        '{1'b1, 8'hFF, 8'h7E, 8'h7E, 8'h7E}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    item_t                  item;
    logic                   empty;
    logic                   pop;
    result_t                result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // decoder shadow state
    cfg_t        cfg_shadow;
    logic [8:0]  pos_count;
    bit          hdr_bad;
    bit          rsv_bad;
    logic [63:0] generation_sum;
    logic [63:0] epoch_sum;
    logic [63:0] identity_sum;
    logic [63:0] time_sum;
    logic [7:0]  code_seen;

    result_t     expected_results[$];
    logic [7:0]  frame_bytes[$];
    int          mismatch_count;
    int          cycle_count;
    bit          hold_off_req;
    bit          sender_quiet;
    bit          receiver_quiet;

    shutdown_frame_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void clear_frame_state();
        pos_count      = '0;
        hdr_bad        = 1'b0;
        rsv_bad        = 1'b0;
        generation_sum = '0;
        epoch_sum      = '0;
        identity_sum   = '0;
        time_sum       = '0;
        code_seen      = '0;
    endfunction

    function automatic bit code_permitted(input logic [7:0] c);
        if (cfg_shadow.frame_mode)
            return c == cfg_shadow.accepted_code || c == cfg_shadow.already_stopping_code ||
                   c == cfg_shadow.rejected_code;
        return c == cfg_shadow.force_stop_code;
    endfunction

    function automatic logic [63:0] header_image();
        return {VERSION_WORD, cfg_shadow.frame_mode ? TYPE_ACK : TYPE_REQUEST, MAGIC_WORD};
    endfunction

    // folds one byte into the shadow frame; returns 1 with the frame status on last
    function automatic bit decode_byte(input logic [7:0] b, input logic is_last,
                                       output result_t r);
        logic [63:0] hdr;
        logic [63:0] lane_val;
        logic [2:0]  frame_status;
        bit          show;
        hdr      = header_image();
        lane_val = 64'(b) << (8 * pos_count[2:0]);
        r        = '0;
        if (pos_count < FRAME_LEN)
        begin
            if (pos_count < HEADER_END)
            begin
                if (b != hdr[8 * pos_count[2:0] +: 8])
                    hdr_bad = 1'b1;
            end
            else if (pos_count < 16)
                generation_sum |= lane_val;
            else if (pos_count < 24)
                epoch_sum |= lane_val;
            else if (pos_count < 32)
                identity_sum |= lane_val;
            else if (pos_count < CODE_POS)
                time_sum |= lane_val;
            else if (pos_count == CODE_POS)
                code_seen = b;
            else if (b != 8'd0)
                rsv_bad = 1'b1;
        end
        if (pos_count != INDEX_MAX)
            pos_count++;
        if (!is_last)
            return 1'b0;

        if (pos_count != FRAME_LEN)
            frame_status = STATUS_BAD_LENGTH;
        else if (hdr_bad)
            frame_status = STATUS_BAD_HEADER;
        else if (rsv_bad)
            frame_status = STATUS_RESERVED;
        else if (generation_sum == 0 || epoch_sum == 0 || identity_sum == 0 ||
                 time_sum == 0 || !code_permitted(code_seen))
            frame_status = STATUS_INVALID;
        else
            frame_status = STATUS_OK;

        show     = frame_status == STATUS_OK || frame_status == STATUS_INVALID;
        r.status = frame_status;
        if (show)
        begin
            r.generation = generation_sum;
            r.epoch      = epoch_sum;
            r.identity   = identity_sum;
            r.time_ns    = time_sum;
            r.code       = code_seen;
        end
        clear_frame_state();
        return 1'b1;
    endfunction

    function automatic logic [63:0] pick_field(input int fill);
        if (fill >= 0)
            return {8{fill[7:0]}};
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7));
            1: return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void build_frame(input frame_row_t row);
        logic [7:0]  body[FRAME_LEN];
        logic [63:0] hdr;
        logic [63:0] field_val;
        logic [7:0]  code_val;
        int          zero_sel;
        hdr      = header_image();
        zero_sel = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++)
            body[i] = hdr[8 * i +: 8];
        for (int f = 0; f < 4; f++)
        begin
            field_val = (row.zero_field && f == zero_sel) ? 64'd0 : pick_field(row.fill);
            for (int k = 0; k < 8; k++)
                body[8 + 8 * f + k] = field_val[8 * k +: 8];
        end
        if (row.code_fault)
        begin
            do
                code_val = 8'($urandom);
            while (code_permitted(code_val));
        end
        else if (!cfg_shadow.frame_mode)
            code_val = cfg_shadow.force_stop_code;
        else
        begin
            case ($urandom_range(0, 2))
                0: code_val = cfg_shadow.accepted_code;
                1: code_val = cfg_shadow.already_stopping_code;
                default: code_val = cfg_shadow.rejected_code;
            endcase
        end
        body[CODE_POS] = code_val;
        for (int i = RESERVED_POS; i < FRAME_LEN; i++)
            body[i] = 8'd0;
        if (row.hdr_fault)
            body[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
        if (row.rsv_fault)
            body[$urandom_range(RESERVED_POS, FRAME_LEN - 1)] = 8'($urandom_range(1, 255));
        if (row.noise)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
                body[i] = 8'($urandom);
        end

        frame_bytes.delete();
        for (int i = 0; i < row.length; i++)
            frame_bytes.push_back(i < FRAME_LEN ? body[i] : 8'($urandom));
    endfunction

    function automatic frame_row_t random_row();
        frame_row_t row;
        int         pick;
        row        = '0;
        row.length = FRAME_LEN;
        row.fill   = -1;
        pick       = $urandom_range(0, 99);
        if (pick < 12)
            row.length = $urandom_range(1, FRAME_LEN - 1);
        else if (pick < 22)
            row.length = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 16);
        else if (pick < 26)
        begin
            row.noise  = 1'b1;
            row.length = $urandom_range(1, FRAME_LEN + 4);
        end
        row.hdr_fault  = $urandom_range(0, 9) == 0;
        row.rsv_fault  = $urandom_range(0, 9) == 0;
        row.zero_field = $urandom_range(0, 7) == 0;
        row.code_fault = $urandom_range(0, 7) == 0;
        if ($urandom_range(0, 15) == 0)
            row.fill = $urandom_range(0, 255);
        return row;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last, input bit use_typed,
                             input result_t typed_value);
        int      gap;
        result_t predicted;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            push <= 1'b0;
            item <= '{data_byte: 8'($urandom), last: 1'($urandom)};
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= '{data_byte: b, last: is_last};
        do
            @(posedge clk);
        while (full);
        if (decode_byte(b, is_last, predicted))
            expected_results.push_back(use_typed ? typed_value : predicted);
        @(negedge clk);
    endtask

    task automatic send_frame(input bit use_typed, input result_t typed_value);
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, use_typed, typed_value);
        end
    endtask

    task automatic put_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic write_config(input cfg_t setting);
        put_register(REG_FRAME_MODE, {7'd0, setting.frame_mode});
        put_register(REG_FORCE_STOP_CODE, setting.force_stop_code);
        put_register(REG_ACCEPTED_CODE, setting.accepted_code);
        put_register(REG_ALREADY_STOPPING, setting.already_stopping_code);
        put_register(REG_REJECTED_CODE, setting.rejected_code);
        cfg_write  <= 1'b0;
        cfg_shadow  = setting;
    endtask

    task automatic settle();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        frame_row_t row;
        cfg_t       setting;
        int         phase_bytes;
        rst_n          = 1'b0;
        push           = 1'b0;
        item           = '0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        hold_off_req   = 1'b0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        cfg_shadow     = '{1'b0, 8'd0, 8'd0, ALREADY_STOPPING_RESET, REJECTED_RESET};
        clear_frame_state();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(directed_rows); i++)
        begin
            build_frame(directed_rows[i]);
            send_frame(directed_rows[i].typed, directed_rows[i].typed_result);
        end
        push <= 1'b0;
        settle();

        // output held back while short frames stream in back to back
        hold_off_req = 1'b1;
        sender_quiet = 1'b1;
        repeat (BURST_FRAMES)
        begin
            row        = random_row();
            row.length = $urandom_range(1, 3);
            build_frame(row);
            send_frame(1'b0, '0);
        end
        push <= 1'b0;
        settle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase < $size(PHASE_SETTINGS))
                setting = PHASE_SETTINGS[phase];
            else
            begin
                setting.frame_mode            = 1'($urandom_range(0, 1));
                setting.force_stop_code       = 8'($urandom);
                setting.accepted_code         = 8'($urandom);
                setting.already_stopping_code = 8'($urandom);
                setting.rejected_code         = 8'($urandom);
            end
            write_config(setting);
            sender_quiet   = $urandom_range(0, 3) == 0;
            receiver_quiet = $urandom_range(0, 3) == 0;
            phase_bytes    = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_frame(random_row());
                phase_bytes += frame_bytes.size();
                send_frame(1'b0, '0);
            end
            push <= 1'b0;
            settle();
        end

        if (!empty)
        begin
            $error("result: output present with no frame pending");
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[shutdown_frame_decoder] OK");
        else
            $display("[shutdown_frame_decoder] ERROR");
        $finish;
    end

    initial
    begin : result_sink
        int      stall;
        result_t got;
        result_t want;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++)
                    @(negedge clk);
            end
            stall = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            got = result;
            if (expected_results.size() == 0)
            begin
                $error("result: unexpected output, status %0d", got.status);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.generation !== want.generation)
                begin
                    $error("generation: expected %h, got %h", want.generation, got.generation);
                    mismatch_count++;
                end
                if (got.epoch !== want.epoch)
                begin
                    $error("epoch: expected %h, got %h", want.epoch, got.epoch);
                    mismatch_count++;
                end
                if (got.identity !== want.identity)
                begin
                    $error("identity: expected %h, got %h", want.identity, got.identity);
                    mismatch_count++;
                end
                if (got.time_ns !== want.time_ns)
                begin
                    $error("time_ns: expected %h, got %h", want.time_ns, got.time_ns);
                    mismatch_count++;
                end
                if (got.code !== want.code)
                begin
                    $error("code: expected %h, got %h", want.code, got.code);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[shutdown_frame_decoder] ERROR");
        $finish;
    end

endmodule
